// ===== hw/rtl/spg_pkg.sv =====
package spg_pkg;

   // Reset values of the configuration registers
   localparam logic [31:0] RATE_NUM_RESET  = 32'd18750;
   localparam logic [15:0] MIN_SPEED_RESET = 16'd19;

   // Timer delay limits
   localparam logic [15:0] DELAY_MAX   = 16'hffff;
   localparam logic [31:0] QUO_SAT_MIN = 32'd65537;

   // Restoring divider: one quotient bit per cycle
   localparam int unsigned DIV_STEPS   = 32;
   localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

   // Input command codes
   typedef enum logic {
      CMD_SPEED = 1'b0,
      CMD_TICK  = 1'b1
   } cmd_type;

   // Configuration register indexes
   typedef enum logic {
      CSR_RATE_NUM  = 1'b0,
      CSR_MIN_SPEED = 1'b1
   } csr_index_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   // Sequencer controls
   typedef struct packed {
      logic req_ready;
      logic div_start;
      logic div_step;
      logic finish;
   } ctrl_type;

endpackage

// ===== hw/rtl/spg_req_if.sv =====
interface spg_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [15:0] speed;

   modport source (output valid, output cmd, output speed, input ready);
   modport sink   (input valid, input cmd, input speed, output ready);
endinterface

// ===== hw/rtl/spg_rsp_if.sv =====
interface spg_rsp_if;
   logic        valid;
   logic        ready;
   logic        step_level;
   logic        dir_level;
   logic [31:0] position;
   logic        running;

   modport source (output valid, output step_level, output dir_level, output position,
                   output running, input ready);
   modport sink   (input valid, input step_level, input dir_level, input position,
                   input running, output ready);
endinterface

// ===== hw/rtl/stepper_step_pulse_generator_top.sv =====
// A tick word, and a speed word inside the dead zone or of zero magnitude,
// give their result word in the cycle after acceptance.
// Other speed words run 32 steps of the restoring divider (one quotient bit per cycle),
// then ST_DONE loads the delay once the result slot is free; no input is taken meanwhile.
// Throughput: one tick word per cycle while the result side keeps up.
// Reset (synchronous, active high) restores the state and both config registers.
module stepper_step_pulse_generator_top
   import spg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   spg_req_if.sink     req_ch,
   spg_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   // Configuration registers
   logic [31:0] rate_num_ff,  rate_num_in;
   logic [15:0] min_speed_ff, min_speed_in;

   // Stepper state
   logic        step_out_ff,  step_out_in;
   logic        dir_out_ff,   dir_out_in;
   logic        forward_ff,   forward_in;
   logic [15:0] pending_ff,   pending_in;
   logic [15:0] reload_ff,    reload_in;
   logic [15:0] tick_cnt_ff,  tick_cnt_in;
   logic        timer_on_ff,  timer_on_in;
   logic        half_ff,      half_in;
   logic [31:0] position_ff,  position_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // Sequencer and divider
   state_type              state_ff, state_in;
   ctrl_type               ctrl;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic [15:0]            rem_ff, rem_in;
   logic [31:0]            quo_ff, quo_in;
   logic [15:0]            div_mag_ff, div_mag_in;

   logic        slot_free;
   logic        accept;
   logic        csr_idx_ok;
   logic [15:0] speed_mag;
   logic [17:0] trial;
   logic [15:0] div_delay;
   logic        div_last;

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign accept    = req_ch.valid && ctrl.req_ready;
   assign div_last  = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign csr_idx_ok = (csr_index == CSR_MIN_SPEED) || (csr_index == CSR_RATE_NUM);

   // Speed magnitude; the most negative value maps to 32768
   assign speed_mag = req_ch.speed[15] ? 16'(~req_ch.speed + 16'd1) : req_ch.speed;

   // Restoring division trial subtract
   assign trial = {1'b0, rem_ff, quo_ff[31]} - {2'b00, div_mag_ff};

   // Quotient to delay: clamp at zero, saturate above the 16-bit range
   always_comb begin
      priority if (quo_ff == 32'd0) begin
         div_delay = 16'd0;
      end else if (quo_ff >= QUO_SAT_MIN) begin
         div_delay = DELAY_MAX;
      end else begin
         div_delay = 16'(quo_ff - 32'd1);
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctrl.div_start) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.req_ready = slot_free;
            ctrl.div_start = req_ch.valid && slot_free && (req_ch.cmd == CMD_SPEED)
                             && (speed_mag >= min_speed_ff) && (speed_mag != 16'd0);
         end
         ST_DIVIDE: begin
            ctrl.div_step = 1'b1;
         end
         ST_DONE: begin
            ctrl.finish = slot_free;
         end
         default: ctrl = '0;
      endcase
   end

   // Datapath and state updates
   always_comb begin
      rate_num_in  = rate_num_ff;
      min_speed_in = min_speed_ff;
      step_out_in  = step_out_ff;
      dir_out_in   = dir_out_ff;
      forward_in   = forward_ff;
      pending_in   = pending_ff;
      reload_in    = reload_ff;
      tick_cnt_in  = tick_cnt_ff;
      timer_on_in  = timer_on_ff;
      half_in      = half_ff;
      position_in  = position_ff;
      div_cnt_in   = div_cnt_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_mag_in   = div_mag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      // Register writes
      if (csr_wr_en && csr_idx_ok) begin
         unique case (csr_index)
            CSR_RATE_NUM:  rate_num_in  = csr_wdata;
            CSR_MIN_SPEED: min_speed_in = csr_wdata[15:0];
            default:       rate_num_in  = rate_num_ff;
         endcase
      end

      // Accepted word
      if (accept) begin
         if (req_ch.cmd == CMD_TICK) begin
            rsp_valid_in = 1'b1;
            if (timer_on_ff) begin
               if (tick_cnt_ff >= reload_ff) begin
                  tick_cnt_in = 16'd0;
                  reload_in   = pending_ff;
                  step_out_in = !step_out_ff;
                  half_in     = !half_ff;
                  if (half_ff) begin
                     position_in = forward_ff ? position_ff + 32'd1 : position_ff - 32'd1;
                  end
               end else begin
                  tick_cnt_in = tick_cnt_ff + 16'd1;
               end
            end
         end else begin
            forward_in = !req_ch.speed[15];
            dir_out_in = !req_ch.speed[15];
            if (speed_mag < min_speed_ff) begin
               timer_on_in  = 1'b0;
               rsp_valid_in = 1'b1;
            end else if (speed_mag == 16'd0) begin
               pending_in   = DELAY_MAX;
               timer_on_in  = 1'b1;
               rsp_valid_in = 1'b1;
            end else begin
               div_cnt_in = '0;
               rem_in     = 16'd0;
               quo_in     = rate_num_ff;
               div_mag_in = speed_mag;
            end
         end
      end

      // One divider step
      if (ctrl.div_step) begin
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         if (!trial[17]) begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[14:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
      end

      // Division done: load the delay and start the timer
      if (ctrl.finish) begin
         pending_in   = div_delay;
         timer_on_in  = 1'b1;
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rate_num_ff  <= RATE_NUM_RESET;
         min_speed_ff <= MIN_SPEED_RESET;
         step_out_ff  <= 1'b0;
         dir_out_ff   <= 1'b0;
         forward_ff   <= 1'b1;
         pending_ff   <= DELAY_MAX;
         reload_ff    <= DELAY_MAX;
         tick_cnt_ff  <= 16'd0;
         timer_on_ff  <= 1'b0;
         half_ff      <= 1'b0;
         position_ff  <= 32'd0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rate_num_ff  <= rate_num_in;
         min_speed_ff <= min_speed_in;
         step_out_ff  <= step_out_in;
         dir_out_ff   <= dir_out_in;
         forward_ff   <= forward_in;
         pending_ff   <= pending_in;
         reload_ff    <= reload_in;
         tick_cnt_ff  <= tick_cnt_in;
         timer_on_ff  <= timer_on_in;
         half_ff      <= half_in;
         position_ff  <= position_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   // Divider payload
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      div_mag_ff <= div_mag_in;
   end

   // Ports; the state registers double as the result word
   assign req_ch.ready      = ctrl.req_ready;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.step_level = step_out_ff;
   assign rsp_ch.dir_level  = dir_out_ff;
   assign rsp_ch.position   = position_ff;
   assign rsp_ch.running    = timer_on_ff;

`ifndef SYNTHESIS
   // A tick word always yields its result on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      accept && (req_ch.cmd == CMD_TICK) |=> rsp_valid_ff)
      else $error("tick word gave no result");

   // No input is taken while the divider works
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) || (state_ff == ST_DONE) |-> !ctrl.req_ready)
      else $error("input taken during division");

   // A waiting result word keeps its position
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |=> $stable(position_ff) && $stable(step_out_ff))
      else $error("result changed while waiting");

   // A stopped timer never toggles the step output
   assert property (@(posedge clock) disable iff (reset)
      !timer_on_ff && (state_ff == ST_IDLE) |=> $stable(step_out_ff))
      else $error("step toggled while stopped");
`endif

endmodule
